FILE: hw/rtl/fba_pkg.sv
// Shared codes and types for the fit block allocator.
package fba_pkg;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 6;
    localparam int AMOUNT_W = 16;
    localparam int POL_W    = 2;
    localparam int BIU_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Any other policy code behaves as first fit.
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

    // Broadcast control to every cell of the chain.
    typedef struct packed {
        logic             load;
        logic             clear;
        logic             mark;
        logic [POL_W-1:0] policy;
    } fba_ctl_t;

endpackage

FILE: hw/rtl/fba_cell.sv
// One table entry of the allocator chain: size, used mark and a search token stage.
module fba_cell
    import fba_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int IDX_W  = 6,
    parameter int SIZE_W = 16,
    parameter int CNT_W  = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fba_ctl_t          ctl,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [SIZE_W-1:0] wr_size,
    input  logic [IDX_W-1:0]  mark_idx,
    input  logic [SIZE_W-1:0] req,
    input  logic [CNT_W-1:0]  count,
    input  logic              in_valid,
    input  logic              in_found,
    input  logic [IDX_W-1:0]  in_pick,
    input  logic [SIZE_W-1:0] in_left,
    output logic              out_valid,
    output logic              out_found,
    output logic [IDX_W-1:0]  out_pick,
    output logic [SIZE_W-1:0] out_left
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [SIZE_W-1:0] size_reg;
    logic              used_reg;
    logic              valid_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [SIZE_W-1:0] left_reg;

    logic              fits;
    logic              take;
    logic [SIZE_W-1:0] left;

    assign fits = (count > MY_CNT) && !used_reg && (size_reg >= req);
    assign left = size_reg - req;

    always_comb
    begin
        take = 1'b0;
        priority if (!in_found)
        begin
            take = fits;
        end
        else if (ctl.policy == POL_BEST)
        begin
            take = fits && (left < in_left);
        end
        else if (ctl.policy == POL_WORST)
        begin
            take = fits && (left > in_left);
        end
        else
        begin
            take = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && (wr_idx == MY_IDX))
        begin
            size_reg <= wr_size;
        end
        found_reg <= in_found | take;
        pick_reg  <= take ? MY_IDX : in_pick;
        left_reg  <= take ? left : in_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            if (ctl.clear)
            begin
                used_reg <= 1'b0;
            end
            else if (ctl.mark && (mark_idx == MY_IDX))
            begin
                used_reg <= 1'b1;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_found = found_reg;
    assign out_pick  = pick_reg;
    assign out_left  = left_reg;

endmodule

FILE: hw/rtl/fit_block_allocator.sv
// Top level of the fit block allocator: command decode, config and the cell chain.
// Load and clear commands complete at the accepting edge and give no result.
// An allocate command sends a search token down a chain of NUM_BLOCKS cells, one
// cell per cycle; its result strobe is registered after the token leaves the last cell.
// busy drops with that strobe, so no new command is taken while a search is in flight.
// Reset clears config, used marks and control; sizes stay undefined until loaded.
module fit_block_allocator
    import fba_pkg::*;
#(
    parameter int NUM_BLOCKS = 64,
    parameter int SIZE_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      op,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [AMOUNT_W-1:0]  amount,
    // result, one cycle per strobe, cannot be stalled
    output logic                 done,
    output logic                 fit_found,
    output logic [SLOT_W-1:0]    chosen_block,
    output logic [AMOUNT_W-1:0]  leftover,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BIU_W-1:0]     cfg_data
);

    localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W   = ((BIU_W > CNT_W) ? BIU_W : CNT_W) + 1;
    localparam int SLOTX_W = ((SLOT_W > IDX_W) ? SLOT_W : IDX_W) + 1;
    localparam int SIZE_W_L = SIZE_WIDTH;

    // config registers
    logic [POL_W-1:0]  fit_policy_reg;
    logic [BIU_W-1:0]  blocks_in_use_reg;
    logic [CNT_W-1:0]  count;

    // command / search control
    logic              accept;
    logic              busy_reg;
    logic              launch_reg;
    logic [SIZE_W_L-1:0] req_reg;
    fba_ctl_t          ctl;

    // result registers
    logic              done_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [SIZE_W_L-1:0] left_reg;

    // chain taps
    logic [NUM_BLOCKS-1:0] cell_valid;
    logic [NUM_BLOCKS-1:0] cell_found;
    logic [IDX_W-1:0]      cell_pick [NUM_BLOCKS];
    logic [SIZE_W_L-1:0]   cell_left [NUM_BLOCKS];

    logic              tail_valid;
    logic              tail_found;
    logic [IDX_W-1:0]  tail_pick;

    // ---------------------------------------------------------------
    // Config port: always ready; the user must write it only while idle (not enforced).
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg    <= POL_FIRST;
            blocks_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIT_POLICY:    fit_policy_reg    <= cfg_data[POL_W-1:0];
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Search count saturates at the table depth.
    always_comb
    begin
        if (CMP_W'(blocks_in_use_reg) > CMP_W'(NUM_BLOCKS))
        begin
            count = CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            count = CNT_W'(blocks_in_use_reg);
        end
    end

    // ---------------------------------------------------------------
    // Command decode. Load and clear act directly on the cells at the
    // transfer edge; an allocate launches a token into cell 0.
    // ---------------------------------------------------------------
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    assign tail_valid = cell_valid[NUM_BLOCKS-1];
    assign tail_found = cell_found[NUM_BLOCKS-1];
    assign tail_pick  = cell_pick[NUM_BLOCKS-1];

    always_comb
    begin
        ctl.load   = accept && (op == OP_LOAD) &&
                     (SLOTX_W'(slot) < SLOTX_W'(NUM_BLOCKS));
        ctl.clear  = accept && (op == OP_CLEAR);
        // winner of a finished search takes its used mark
        ctl.mark   = tail_valid && tail_found;
        ctl.policy = fit_policy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            launch_reg <= accept && (op == OP_ALLOC);
            done_reg   <= tail_valid;
            if (accept && (op == OP_ALLOC))
            begin
                busy_reg <= 1'b1;
            end
            else if (tail_valid)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_ALLOC))
        begin
            req_reg <= SIZE_W_L'(amount);
        end
        found_reg <= tail_found;
        pick_reg  <= tail_pick;
        left_reg  <= cell_left[NUM_BLOCKS-1];
    end

    // ---------------------------------------------------------------
    // Cell chain: entry k compares itself with the running candidate and
    // hands the updated candidate to entry k+1 on the next cycle.
    // ---------------------------------------------------------------
    for (genvar k = 0; k < NUM_BLOCKS; k++)
    begin : g_cell
        logic              in_valid;
        logic              in_found;
        logic [IDX_W-1:0]  in_pick;
        logic [SIZE_W_L-1:0] in_left;

        if (k == 0)
        begin : g_head
            assign in_valid = launch_reg;
            assign in_found = 1'b0;
            assign in_pick  = '0;
            assign in_left  = '0;
        end
        else
        begin : g_link
            assign in_valid = cell_valid[k-1];
            assign in_found = cell_found[k-1];
            assign in_pick  = cell_pick[k-1];
            assign in_left  = cell_left[k-1];
        end

        fba_cell #(
            .IDX    (k),
            .IDX_W  (IDX_W),
            .SIZE_W (SIZE_W_L),
            .CNT_W  (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_idx    (IDX_W'(slot)),
            .wr_size   (SIZE_W_L'(amount)),
            .mark_idx  (tail_pick),
            .req       (req_reg),
            .count     (count),
            .in_valid  (in_valid),
            .in_found  (in_found),
            .in_pick   (in_pick),
            .in_left   (in_left),
            .out_valid (cell_valid[k]),
            .out_found (cell_found[k]),
            .out_pick  (cell_pick[k]),
            .out_left  (cell_left[k])
        );
    end

    // outputs; pick and leftover stay zero on no fit since the token starts clear
    assign done         = done_reg;
    assign fit_found    = found_reg;
    assign chosen_block = SLOT_W'(pick_reg);
    assign leftover     = AMOUNT_W'(left_reg);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // at most one search token in flight
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones({cell_valid, launch_reg}) <= 1))
        else $error("more than one search token in the chain");

    // no token in the chain while idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg |-> (cell_valid == '0) && !launch_reg))
        else $error("search token present while idle");

    // a result strobe follows the token leaving the last cell
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg |-> $past(tail_valid) && !$past(accept)))
        else $error("result strobe without a finished search");

    // a launch only follows an allocate transfer
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (launch_reg |-> busy_reg && $past(accept) && ($past(op) == OP_ALLOC)))
        else $error("search launched without an allocate command");

    // the chosen block lies within the table
    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((done_reg && found_reg) |-> (int'(pick_reg) < NUM_BLOCKS)))
        else $error("chosen block outside the table");

endmodule

FILE: sim/fit_block_allocator_check.sv
// Checker for the fit block allocator: tracks registers and commands, predicts and compares grants.
module fit_block_allocator_check
    import fba_pkg::*;
#(
    parameter int NUM_BLOCKS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [OP_W-1:0]      op,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [AMOUNT_W-1:0]  amount,
    input  logic                 done,
    input  logic                 fit_found,
    input  logic [SLOT_W-1:0]    chosen_block,
    input  logic [AMOUNT_W-1:0]  leftover,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BIU_W-1:0]     cfg_data,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   blk;
        logic [AMOUNT_W-1:0] left;
    } grant_t;

    logic [AMOUNT_W-1:0] block_sizes [NUM_BLOCKS];
    logic                taken       [NUM_BLOCKS];
    logic [POL_W-1:0]    policy;
    logic [BIU_W-1:0]    search_len;
    grant_t              grant_q [$];

    // Scan the free blocks in range and claim the one the policy picks.
    function automatic grant_t grant_block(input logic [AMOUNT_W-1:0] req);
        grant_t              g;
        int                  limit;
        bit                  stop;
        logic [AMOUNT_W-1:0] rest;
        g     = '0;
        stop  = 1'b0;
        limit = (search_len > NUM_BLOCKS) ? NUM_BLOCKS : int'(search_len);
        for (int k = 0; k < limit && !stop; k++)
        begin
            if (!taken[k] && block_sizes[k] >= req)
            begin
                rest = block_sizes[k] - req;
                if (!g.found)
                begin
                    g.found = 1'b1;
                    g.blk   = SLOT_W'(k);
                    g.left  = rest;
                    // unknown policy codes fall back to first fit
                    stop    = (policy != POL_BEST) && (policy != POL_WORST);
                end
                else if ((policy == POL_BEST && rest < g.left) ||
                         (policy == POL_WORST && rest > g.left))
                begin
                    g.blk  = SLOT_W'(k);
                    g.left = rest;
                end
            end
        end
        if (g.found)
            taken[g.blk] = 1'b1;
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grant_t want;
        if (!rst_n)
        begin
            policy     = POL_FIRST;
            search_len = '0;
            for (int k = 0; k < NUM_BLOCKS; k++)
            begin
                taken[k]       = 1'b0;
                block_sizes[k] = '0;
            end
            grant_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // results first: a new command may be taken on the strobe edge
            if (done)
            begin
                if (grant_q.size() == 0)
                begin
                    $error("result strobe with no allocate outstanding");
                    errors++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (fit_found !== want.found)
                    begin
                        $error("fit_found: expected %0d, actual %0d", want.found, fit_found);
                        errors++;
                    end
                    if (chosen_block !== want.blk)
                    begin
                        $error("chosen_block: expected %0d, actual %0d", want.blk, chosen_block);
                        errors++;
                    end
                    if (leftover !== want.left)
                    begin
                        $error("leftover: expected %0d, actual %0d", want.left, leftover);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FIT_POLICY)
                    policy = cfg_data[POL_W-1:0];
                else if (cfg_index == REG_BLOCKS_IN_USE)
                    search_len = cfg_data;
            end
            if (start && !busy)
            begin
                case (op)
                    OP_LOAD:
                        if (slot < NUM_BLOCKS)
                            block_sizes[slot] = amount;
                    OP_ALLOC:
                        grant_q.push_back(grant_block(amount));
                    OP_CLEAR:
                        for (int k = 0; k < NUM_BLOCKS; k++)
                            taken[k] = 1'b0;
                    default:
                        ;
                endcase
            end
            pending = grant_q.size();
        end
    end

endmodule

FILE: sim/fit_block_allocator_test.sv
// Testbench top for the fit block allocator: stimulus, timeout and verdict.
module fit_block_allocator_test;
    import fba_pkg::*;

    localparam int NUM_BLOCKS  = 64;
    localparam int SIZE_WIDTH  = 16;
    // Slowest run: ~1350 commands, each after a random idle gap, allocates with a
    // full chain search, plus 14 register phases with drain; the limit leaves a
    // wide margin on top of that.
    localparam int CYCLE_LIMIT  = 800000;
    // An allocate's result is taken once its token has crossed the whole chain.
    localparam int DRAIN_CYCLES = NUM_BLOCKS + 8;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 125;

    // Codes the package leaves unnamed; the block must ignore or tolerate them.
    localparam logic [OP_W-1:0]      OP_UNKNOWN  = 2'd3;
    localparam logic [POL_W-1:0]     POL_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [AMOUNT_W-1:0]  SIZE_MAX    = '1;
    localparam logic [POL_W-1:0]     POL_ORDER [4] =
        '{POL_FIRST, POL_BEST, POL_WORST, POL_UNKNOWN};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic [OP_W-1:0]      op        = OP_LOAD;
    logic [SLOT_W-1:0]    slot      = '0;
    logic [AMOUNT_W-1:0]  amount    = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FIT_POLICY;
    logic [BIU_W-1:0]     cfg_data  = '0;
    logic                 busy;
    logic                 done;
    logic                 fit_found;
    logic [SLOT_W-1:0]    chosen_block;
    logic [AMOUNT_W-1:0]  leftover;
    logic                 cfg_ready;

    int errors;
    int pending;
    int cycles  = 0;
    int item_no = 0;
    int cur_len = 0;

    // Sizes written so far; used only to aim requests at real blocks.
    logic [AMOUNT_W-1:0] sizes_loaded [NUM_BLOCKS];

    always #10 clk = ~clk;

    fit_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .slot         (slot),
        .amount       (amount),
        .done         (done),
        .fit_found    (fit_found),
        .chosen_block (chosen_block),
        .leftover     (leftover),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    fit_block_allocator_check #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .slot         (slot),
        .amount       (amount),
        .done         (done),
        .fit_found    (fit_found),
        .chosen_block (chosen_block),
        .leftover     (leftover),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    // Hard stop if the block hangs or results never arrive.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle cycles ahead of a transfer; every third run of 40 items goes back to back.
    function automatic int pick_gap();
        if ((item_no / 40) % 3 == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // One command transfer. start stays high when the next item follows with no gap.
    // busy is sampled at the falling edge so the accept decision is race free.
    task automatic send(input logic [OP_W-1:0] o, input logic [SLOT_W-1:0] s,
                        input logic [AMOUNT_W-1:0] a);
        int gap;
        bit free;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        op     <= o;
        slot   <= s;
        amount <= a;
        do
        begin
            @(negedge clk);
            free = !busy;
            @(posedge clk);
        end
        while (!free);
        if (o == OP_LOAD)
            sizes_loaded[s] = a;
        item_no++;
    endtask

    // One register write transfer; the caller drops cfg_valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BIU_W-1:0] data);
        int gap;
        bit ok;
        gap = $urandom_range(0, 14);
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
    endtask

    // Drop start, wait out every outstanding grant, then let the block go quiet.
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Registers only change while the block is idle. Upper data bits of the
    // policy write are junk the block must drop; spare indexes must be ignored.
    task automatic configure(input logic [POL_W-1:0] pol, input int len);
        settle();
        write_reg(REG_FIT_POLICY, {(BIU_W-POL_W)'($urandom_range(0, 31)), pol});
        write_reg(REG_BLOCKS_IN_USE, BIU_W'(len));
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, BIU_W'($urandom));
        cfg_valid <= 1'b0;
        cur_len = len;
    endtask

    // Block size for a load: wide spread, clusters of small sizes for ties, extremes.
    function automatic logic [AMOUNT_W-1:0] block_size_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return AMOUNT_W'($urandom);
        if (r < 50)
            return AMOUNT_W'($urandom_range(0, 31));
        if (r < 55)
            return SIZE_MAX;
        if (r < 60)
            return '0;
        return AMOUNT_W'($urandom_range(256, 8191));
    endfunction

    // Request size aimed at a block in the search range: exact fits, near fits,
    // zero, just too big, and fully random.
    function automatic logic [AMOUNT_W-1:0] request_pick();
        int k;
        int r;
        int base;
        int v;
        k    = $urandom_range(0, (cur_len == 0 || cur_len > NUM_BLOCKS) ?
                                 NUM_BLOCKS - 1 : cur_len - 1);
        base = int'(sizes_loaded[k]);
        r    = $urandom_range(0, 99);
        if (r < 30)
            return AMOUNT_W'(base);
        if (r < 60)
            return AMOUNT_W'(base - int'($urandom_range(0, base < 255 ? base : 255)));
        if (r < 70)
            return AMOUNT_W'($urandom_range(0, 3));
        if (r < 80)
        begin
            v = base + int'($urandom_range(1, 16));
            return (v > int'(SIZE_MAX)) ? SIZE_MAX : AMOUNT_W'(v);
        end
        return AMOUNT_W'($urandom_range(0, 65535));
    endfunction

    function automatic int search_len_pick(input int p);
        case (p)
            0:       return NUM_BLOCKS;
            1:       return 127;                       // saturates to the table depth
            2:       return 16;
            4:       return 1;
            6:       return 0;                         // nothing searched, every request misses
            7:       return $urandom_range(NUM_BLOCKS + 1, 126);
            8:       return $urandom_range(2, NUM_BLOCKS - 1);
            default: return NUM_BLOCKS;
        endcase
    endfunction

    initial
    begin : stimulus
        int r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole table so no search ever reaches an unwritten entry.
        // The largest size is kept out so a full-size request has one taker below.
        for (int s = 0; s < NUM_BLOCKS; s++)
            send(OP_LOAD, SLOT_W'(s), AMOUNT_W'($urandom_range(1, 16'hFFFE)));

        // Directed: first fit, extremes of every field, no fit, zero request, unknown op.
        configure(POL_FIRST, NUM_BLOCKS);
        send(OP_LOAD, '0, SIZE_MAX);
        send(OP_LOAD, '1, '0);
        send(OP_LOAD, SLOT_W'(5), AMOUNT_W'(100));
        send(OP_ALLOC, '0, SIZE_MAX);
        send(OP_ALLOC, '1, SIZE_MAX);
        send(OP_ALLOC, '0, '0);
        send(OP_UNKNOWN, '1, SIZE_MAX);
        send(OP_CLEAR, '0, '0);
        send(OP_ALLOC, '0, AMOUNT_W'(100));

        // Worst fit with an oversized search count; exact fit must still be taken.
        configure(POL_WORST, 127);
        send(OP_CLEAR, '1, SIZE_MAX);
        send(OP_ALLOC, '0, SIZE_MAX);
        send(OP_ALLOC, '0, '0);

        // Best fit: exact match, then zero request lands on the empty block.
        configure(POL_BEST, NUM_BLOCKS);
        send(OP_CLEAR, '0, '0);
        send(OP_ALLOC, '0, AMOUNT_W'(100));
        send(OP_ALLOC, '0, AMOUNT_W'(1));
        send(OP_ALLOC, '0, '0);

        // Unknown policy acts as first fit; one-block search runs dry on the second try.
        configure(POL_UNKNOWN, 1);
        send(OP_CLEAR, '0, '0);
        send(OP_ALLOC, '0, '0);
        send(OP_ALLOC, '0, '0);

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            configure(POL_ORDER[p % 4], search_len_pick(p));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    send(OP_ALLOC, SLOT_W'($urandom), request_pick());
                else if (r < 80)
                    send(OP_LOAD, SLOT_W'($urandom), block_size_pick());
                else if (r < 92)
                    send(OP_CLEAR, SLOT_W'($urandom), AMOUNT_W'($urandom));
                else
                    send(OP_UNKNOWN, SLOT_W'($urandom), AMOUNT_W'($urandom));
            end
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
